### hw/rtl/whp_pkg.sv
// shared types, codes and constants of the wave header parser
package whp_pkg;

  // field widths
  localparam int ByteW   = 8;
  localparam int KindW   = 2;
  localparam int ErrW    = 3;
  localparam int HalfW   = 16;
  localparam int WordW   = 32;
  localparam int ShiftW  = 24;
  localparam int CountW  = 2;
  // packed result data: 3+16+32+32+16+16+32+8 = 155 bits, padded to bytes
  localparam int OutDataW = 160;

  // result kinds
  localparam logic [KindW-1:0] KIND_FORMAT = 2'd0;
  localparam logic [KindW-1:0] KIND_DATA   = 2'd1;
  localparam logic [KindW-1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [ErrW-1:0] ERR_NONE    = 3'd0;
  localparam logic [ErrW-1:0] ERR_RIFF    = 3'd1;
  localparam logic [ErrW-1:0] ERR_WAVE    = 3'd2;
  localparam logic [ErrW-1:0] ERR_FMT_TAG = 3'd3;
  localparam logic [ErrW-1:0] ERR_NOT_PCM = 3'd4;

  // chunk tags as little-endian words
  localparam logic [WordW-1:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [WordW-1:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [WordW-1:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [WordW-1:0] TAG_DATA = 32'h6174_6164;
  localparam logic [WordW-1:0] BASE_FMT_SIZE = 32'd16;
  localparam logic [HalfW-1:0] FMT_PCM = 16'd1;

  // one input word
  typedef struct packed {
    logic [ByteW-1:0] file_byte;
    logic             start_of_file;
  } item_t;

  // one result word
  typedef struct packed {
    logic [KindW-1:0] result_kind;
    logic [ErrW-1:0]  error_code;
    logic [HalfW-1:0] channel_count;
    logic [WordW-1:0] sample_rate;
    logic [WordW-1:0] byte_rate;
    logic [HalfW-1:0] block_alignment;
    logic [HalfW-1:0] sample_bits;
    logic [WordW-1:0] data_length;
    logic [ByteW-1:0] data_byte;
    logic             last_data;
  } result_t;

endpackage

### hw/rtl/whp_in_stage.sv
// input register holding one file byte word ahead of the parser
module whp_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  whp_pkg::item_t in_item,
  input  logic           pop,
  output logic           held_valid,
  output whp_pkg::item_t held_item
);
  import whp_pkg::*;

  // free when empty or when the parser takes the held word
  assign in_ready = !held_valid || pop;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

### hw/rtl/whp_parser.sv
// header parse state and the single-pass step logic for one byte
module whp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  whp_pkg::item_t   in_item,
  input  logic             out_ready,
  output logic             take,
  output logic             res_valid,
  output whp_pkg::result_t res
);
  import whp_pkg::*;

  localparam logic [4:0] PH_RIFF       = 5'd0;
  localparam logic [4:0] PH_RIFF_SIZE  = 5'd1;
  localparam logic [4:0] PH_WAVE       = 5'd2;
  localparam logic [4:0] PH_FMT        = 5'd3;
  localparam logic [4:0] PH_FMT_SIZE   = 5'd4;
  localparam logic [4:0] PH_CODE       = 5'd5;
  localparam logic [4:0] PH_CHANNELS   = 5'd6;
  localparam logic [4:0] PH_RATE       = 5'd7;
  localparam logic [4:0] PH_BYTE_RATE  = 5'd8;
  localparam logic [4:0] PH_ALIGN      = 5'd9;
  localparam logic [4:0] PH_BITS       = 5'd10;
  localparam logic [4:0] PH_EXTRA_SIZE = 5'd11;
  localparam logic [4:0] PH_EXTRA_SKIP = 5'd12;
  localparam logic [4:0] PH_CHUNK_TAG  = 5'd13;
  localparam logic [4:0] PH_CHUNK_SIZE = 5'd14;
  localparam logic [4:0] PH_CHUNK_SKIP = 5'd15;
  localparam logic [4:0] PH_DATA_SIZE  = 5'd16;
  localparam logic [4:0] PH_DATA       = 5'd17;
  localparam logic [4:0] PH_DONE       = 5'd18;

  logic [4:0]        phase, phase_next;
  logic [CountW-1:0] field_byte_count, field_byte_count_next;
  logic [ShiftW-1:0] field_shift, field_shift_next;
  logic [WordW-1:0]  skip_remaining, skip_remaining_next;
  logic [WordW-1:0]  data_remaining, data_remaining_next;
  logic              fmt_extended, fmt_extended_next;
  logic              fmt_is_pcm, fmt_is_pcm_next;
  logic [HalfW-1:0]  held_channels, held_channels_next;
  logic [WordW-1:0]  held_rate, held_rate_next;
  logic [WordW-1:0]  held_byte_rate, held_byte_rate_next;
  logic [HalfW-1:0]  held_alignment, held_alignment_next;
  logic [HalfW-1:0]  held_sample_bits, held_sample_bits_next;

  logic [4:0]        cur_phase;
  logic [CountW-1:0] cur_count;
  logic [ShiftW-1:0] cur_shift;
  logic [WordW-1:0]  assembled;
  logic              half_field;
  logic              gathering;
  logic              complete;
  logic              emit;
  result_t           res_next;

  // a word moves only when the result register can take it
  assign take      = in_valid && out_ready;
  assign res_valid = take && emit;
  assign res       = res_next;

  // start of file restarts the field gatherer from the reset state
  assign cur_phase = in_item.start_of_file ? PH_RIFF : phase;
  assign cur_count = in_item.start_of_file ? '0 : field_byte_count;
  assign cur_shift = in_item.start_of_file ? '0 : field_shift;

  // little-endian field assembly
  assign assembled = {{(WordW-ShiftW){1'b0}}, cur_shift}
                   | ({{(WordW-ByteW){1'b0}}, in_item.file_byte} << {cur_count, 3'b000});

  // field length and completion
  always_comb begin
    half_field = 1'b0;
    gathering  = 1'b1;
    case (cur_phase)
      PH_CODE, PH_CHANNELS, PH_ALIGN, PH_BITS, PH_EXTRA_SIZE: begin
        half_field = 1'b1;
      end
      PH_RIFF, PH_RIFF_SIZE, PH_WAVE, PH_FMT, PH_FMT_SIZE, PH_RATE, PH_BYTE_RATE,
      PH_CHUNK_TAG, PH_CHUNK_SIZE, PH_DATA_SIZE: begin
        half_field = 1'b0;
      end
      default: begin
        gathering = 1'b0;
      end
    endcase
  end

  assign complete = half_field ? (cur_count != '0) : (cur_count == 2'd3);

  // step logic
  always_comb begin
    phase_next            = cur_phase;
    field_byte_count_next = cur_count;
    field_shift_next      = cur_shift;
    skip_remaining_next   = skip_remaining;
    data_remaining_next   = data_remaining;
    fmt_extended_next     = fmt_extended;
    fmt_is_pcm_next       = fmt_is_pcm;
    held_channels_next    = held_channels;
    held_rate_next        = held_rate;
    held_byte_rate_next   = held_byte_rate;
    held_alignment_next   = held_alignment;
    held_sample_bits_next = held_sample_bits;
    emit                  = 1'b0;
    res_next              = '0;

    // gatherer bookkeeping
    if (gathering) begin
      if (complete) begin
        field_byte_count_next = '0;
        field_shift_next      = '0;
      end else begin
        field_byte_count_next = cur_count + 2'd1;
        field_shift_next      = assembled[ShiftW-1:0];
      end
    end

    case (cur_phase)
      PH_RIFF: begin
        if (complete) begin
          if (assembled != TAG_RIFF) begin
            emit                 = 1'b1;
            res_next.result_kind = KIND_ERROR;
            res_next.error_code  = ERR_RIFF;
            phase_next           = PH_DONE;
          end else begin
            phase_next = PH_RIFF_SIZE;
          end
        end
      end
      PH_RIFF_SIZE: begin
        if (complete) begin
          phase_next = PH_WAVE;
        end
      end
      PH_WAVE: begin
        if (complete) begin
          if (assembled != TAG_WAVE) begin
            emit                 = 1'b1;
            res_next.result_kind = KIND_ERROR;
            res_next.error_code  = ERR_WAVE;
            phase_next           = PH_DONE;
          end else begin
            phase_next = PH_FMT;
          end
        end
      end
      PH_FMT: begin
        if (complete) begin
          if (assembled != TAG_FMT) begin
            emit                 = 1'b1;
            res_next.result_kind = KIND_ERROR;
            res_next.error_code  = ERR_FMT_TAG;
            phase_next           = PH_DONE;
          end else begin
            phase_next = PH_FMT_SIZE;
          end
        end
      end
      PH_FMT_SIZE: begin
        if (complete) begin
          fmt_extended_next = assembled > BASE_FMT_SIZE;
          phase_next        = PH_CODE;
        end
      end
      PH_CODE: begin
        if (complete) begin
          fmt_is_pcm_next = assembled[HalfW-1:0] == FMT_PCM;
          phase_next      = PH_CHANNELS;
        end
      end
      PH_CHANNELS: begin
        if (complete) begin
          held_channels_next = assembled[HalfW-1:0];
          phase_next         = PH_RATE;
        end
      end
      PH_RATE: begin
        if (complete) begin
          held_rate_next = assembled;
          phase_next     = PH_BYTE_RATE;
        end
      end
      PH_BYTE_RATE: begin
        if (complete) begin
          held_byte_rate_next = assembled;
          phase_next          = PH_ALIGN;
        end
      end
      PH_ALIGN: begin
        if (complete) begin
          held_alignment_next = assembled[HalfW-1:0];
          phase_next          = PH_BITS;
        end
      end
      PH_BITS: begin
        if (complete) begin
          held_sample_bits_next = assembled[HalfW-1:0];
          if (fmt_extended) begin
            phase_next = PH_EXTRA_SIZE;
          end else if (!fmt_is_pcm) begin
            emit                 = 1'b1;
            res_next.result_kind = KIND_ERROR;
            res_next.error_code  = ERR_NOT_PCM;
            phase_next           = PH_DONE;
          end else begin
            phase_next = PH_CHUNK_TAG;
          end
        end
      end
      PH_EXTRA_SIZE: begin
        if (complete) begin
          skip_remaining_next = {{(WordW-HalfW){1'b0}}, assembled[HalfW-1:0]};
          if (assembled[HalfW-1:0] != '0) begin
            phase_next = PH_EXTRA_SKIP;
          end else if (!fmt_is_pcm) begin
            emit                 = 1'b1;
            res_next.result_kind = KIND_ERROR;
            res_next.error_code  = ERR_NOT_PCM;
            phase_next           = PH_DONE;
          end else begin
            phase_next = PH_CHUNK_TAG;
          end
        end
      end
      PH_EXTRA_SKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) begin
          if (!fmt_is_pcm) begin
            emit                 = 1'b1;
            res_next.result_kind = KIND_ERROR;
            res_next.error_code  = ERR_NOT_PCM;
            phase_next           = PH_DONE;
          end else begin
            phase_next = PH_CHUNK_TAG;
          end
        end
      end
      PH_CHUNK_TAG: begin
        if (complete) begin
          phase_next = (assembled == TAG_DATA) ? PH_DATA_SIZE : PH_CHUNK_SIZE;
        end
      end
      PH_CHUNK_SIZE: begin
        if (complete) begin
          skip_remaining_next = assembled;
          phase_next = (assembled == '0) ? PH_CHUNK_TAG : PH_CHUNK_SKIP;
        end
      end
      PH_CHUNK_SKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) begin
          phase_next = PH_CHUNK_TAG;
        end
      end
      PH_DATA_SIZE: begin
        if (complete) begin
          data_remaining_next      = assembled;
          emit                     = 1'b1;
          res_next.result_kind     = KIND_FORMAT;
          res_next.error_code      = ERR_NONE;
          res_next.channel_count   = held_channels;
          res_next.sample_rate     = held_rate;
          res_next.byte_rate       = held_byte_rate;
          res_next.block_alignment = held_alignment;
          res_next.sample_bits     = held_sample_bits;
          res_next.data_length     = assembled;
          phase_next = (assembled == '0) ? PH_DONE : PH_DATA;
        end
      end
      PH_DATA: begin
        data_remaining_next  = data_remaining - 32'd1;
        emit                 = 1'b1;
        res_next.result_kind = KIND_DATA;
        res_next.error_code  = ERR_NONE;
        res_next.data_byte   = in_item.file_byte;
        if (data_remaining == 32'd1) begin
          res_next.last_data = 1'b1;
          phase_next         = PH_DONE;
        end
      end
      default: begin
        // finished or failed: drop bytes until the next start of file
        phase_next = cur_phase;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RIFF;
      field_byte_count <= '0;
      field_shift      <= '0;
    end else if (take) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      field_shift      <= field_shift_next;
    end
  end

  // header fields and counters, always written before they are read
  always_ff @(posedge clk) begin
    if (take) begin
      skip_remaining   <= skip_remaining_next;
      data_remaining   <= data_remaining_next;
      fmt_extended     <= fmt_extended_next;
      fmt_is_pcm       <= fmt_is_pcm_next;
      held_channels    <= held_channels_next;
      held_rate        <= held_rate_next;
      held_byte_rate   <= held_byte_rate_next;
      held_alignment   <= held_alignment_next;
      held_sample_bits <= held_sample_bits_next;
    end
  end

endmodule

### hw/rtl/whp_out_stage.sv
// result register between the parser and the output stream
module whp_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  whp_pkg::result_t res,
  output logic             can_take,
  output logic             out_valid,
  input  logic             out_ready,
  output whp_pkg::result_t out_res
);
  import whp_pkg::*;

  // room when empty or when the current word leaves this cycle
  assign can_take = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_take) begin
      out_valid <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (can_take && res_valid) begin
      out_res <= res;
    end
  end

endmodule

### hw/rtl/wav_header_parser.sv
// top level of the wave file header parser
//
//  channel | dir | tdata                  | tuser          | tlast
//  s_axis  | in  | file_byte [7:0]        | start_of_file  | -
//  m_axis  | out | format/error/data word | result_kind    | last_data
//
// one byte word is taken per cycle when the result side keeps up
// an accepted word goes from the input register through the parse step into the result register
// only bytes that make a result occupy the result register
// rst is synchronous and returns the parser to the riff tag search
// a stalled result side holds the input register, which then drops s_tready
module wav_header_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [whp_pkg::ByteW-1:0]    s_tdata,   // [7:0] file_byte
  input  logic                         s_tuser,   // [0] start_of_file
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [whp_pkg::OutDataW-1:0] m_tdata,   // [2:0] error_code, [18:3] channel_count,
                                                  // [50:19] sample_rate, [82:51] byte_rate,
                                                  // [98:83] block_alignment,
                                                  // [114:99] sample_bits,
                                                  // [146:115] data_length,
                                                  // [154:147] data_byte, rest zero
  output logic [whp_pkg::KindW-1:0]    m_tuser,   // [1:0] result_kind
  output logic                         m_tlast    // last_data
);
  import whp_pkg::*;

  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    pop;
  logic    can_take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.file_byte     = s_tdata;
  assign in_item.start_of_file = s_tuser;

  // input register
  whp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (in_item),
    .pop        (pop),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // parse step
  whp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (held_valid),
    .in_item   (held_item),
    .out_ready (can_take),
    .take      (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  whp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .can_take  (can_take),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // output packing
  assign m_tdata = {5'b00000, out_res.data_byte, out_res.data_length, out_res.sample_bits,
                    out_res.block_alignment, out_res.byte_rate, out_res.sample_rate,
                    out_res.channel_count, out_res.error_code};
  assign m_tuser = out_res.result_kind;
  assign m_tlast = out_res.last_data;

  // an empty result register never stalls the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while result register empty");

  // errors carry a code, other results carry none
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == KIND_ERROR) == (m_tdata[ErrW-1:0] != ERR_NONE)))
    else $error("error code does not match result kind");

  // the last mark only appears on data words
  a_last_on_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == KIND_DATA)
    else $error("last mark on a non-data word");

  // a result is loaded only from a word the parser took
  a_result_from_take: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pop)
    else $error("result without a parsed word");

endmodule

### tb/tb_wav_header_parser.sv
// self-checking testbench of the wave file header parser, with a byte-level parse tracker
`timescale 1ns / 100ps

module tb_wav_header_parser;
  import whp_pkg::*;

  // parse phases of the tracker
  typedef enum logic [4:0] {
    P_RIFF_TAG, P_RIFF_SIZE, P_WAVE_TAG, P_FMT_TAG, P_FMT_SIZE, P_CODE, P_CHANNELS,
    P_RATE, P_BYTE_RATE, P_ALIGN, P_BITS, P_EXTRA_SIZE, P_EXTRA_SKIP, P_CHUNK_TAG,
    P_CHUNK_SIZE, P_CHUNK_SKIP, P_DATA_SIZE, P_DATA, P_DONE
  } parse_phase_t;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned FILE_BYTE_GOAL = 1800;

  // tracks the parse of the byte stream and checks the results against it
  class wav_parse_tracker;
    parse_phase_t phase;
    logic [1:0]   byte_count;
    logic [31:0]  shift_word, skip_left, fmt_size, data_left, rate, byte_rate;
    logic [15:0]  fmt_code, channels, align, bits;
    result_t      parsed_results[$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      phase      = P_RIFF_TAG;
      byte_count = '0;
      shift_word = '0;
      skip_left  = '0;
      fmt_size   = '0;
      data_left  = '0;
      rate       = '0;
      byte_rate  = '0;
      fmt_code   = '0;
      channels   = '0;
      align      = '0;
      bits       = '0;
    endfunction

    // little-endian field gather, 1 when the field is complete
    function bit gather(input logic [7:0] b, input int unsigned nbytes,
                        output logic [31:0] value);
      shift_word |= 32'(b) << (byte_count * 8);
      value = shift_word;
      if (int'(byte_count) + 1 >= nbytes) begin
        shift_word = '0;
        byte_count = '0;
        return 1'b1;
      end
      byte_count++;
      return 1'b0;
    endfunction

    function result_t blank(logic [KindW-1:0] kind, logic [ErrW-1:0] err);
      result_t r;
      r = '0;
      r.result_kind = kind;
      r.error_code  = err;
      return r;
    endfunction

    function void fail(logic [ErrW-1:0] err);
      parsed_results.push_back(blank(KIND_ERROR, err));
      phase = P_DONE;
    endfunction

    // pcm check at the end of the fmt part
    function void close_fmt();
      if (fmt_code != FMT_PCM) fail(ERR_NOT_PCM);
      else phase = P_CHUNK_TAG;
    endfunction

    function void note_byte(logic [7:0] b, logic sof);
      logic [31:0] v;
      result_t     r;
      if (sof) restart();
      case (phase)
        P_RIFF_TAG: if (gather(b, 4, v)) begin
          if (v != TAG_RIFF) fail(ERR_RIFF);
          else phase = P_RIFF_SIZE;
        end
        P_RIFF_SIZE: if (gather(b, 4, v)) phase = P_WAVE_TAG;
        P_WAVE_TAG: if (gather(b, 4, v)) begin
          if (v != TAG_WAVE) fail(ERR_WAVE);
          else phase = P_FMT_TAG;
        end
        P_FMT_TAG: if (gather(b, 4, v)) begin
          if (v != TAG_FMT) fail(ERR_FMT_TAG);
          else phase = P_FMT_SIZE;
        end
        P_FMT_SIZE: if (gather(b, 4, v)) begin
          fmt_size = v;
          phase = P_CODE;
        end
        P_CODE: if (gather(b, 2, v)) begin
          fmt_code = v[15:0];
          phase = P_CHANNELS;
        end
        P_CHANNELS: if (gather(b, 2, v)) begin
          channels = v[15:0];
          phase = P_RATE;
        end
        P_RATE: if (gather(b, 4, v)) begin
          rate = v;
          phase = P_BYTE_RATE;
        end
        P_BYTE_RATE: if (gather(b, 4, v)) begin
          byte_rate = v;
          phase = P_ALIGN;
        end
        P_ALIGN: if (gather(b, 2, v)) begin
          align = v[15:0];
          phase = P_BITS;
        end
        P_BITS: if (gather(b, 2, v)) begin
          bits = v[15:0];
          if (fmt_size > BASE_FMT_SIZE) phase = P_EXTRA_SIZE;
          else close_fmt();
        end
        P_EXTRA_SIZE: if (gather(b, 2, v)) begin
          skip_left = {16'd0, v[15:0]};
          if (skip_left == 0) close_fmt();
          else phase = P_EXTRA_SKIP;
        end
        P_EXTRA_SKIP: begin
          skip_left--;
          if (skip_left == 0) close_fmt();
        end
        P_CHUNK_TAG: if (gather(b, 4, v)) begin
          if (v == TAG_DATA) phase = P_DATA_SIZE;
          else phase = P_CHUNK_SIZE;
        end
        P_CHUNK_SIZE: if (gather(b, 4, v)) begin
          skip_left = v;
          if (v == 0) phase = P_CHUNK_TAG;
          else phase = P_CHUNK_SKIP;
        end
        P_CHUNK_SKIP: begin
          skip_left--;
          if (skip_left == 0) phase = P_CHUNK_TAG;
        end
        // data size complete: one format word
        P_DATA_SIZE: if (gather(b, 4, v)) begin
          data_left = v;
          r = blank(KIND_FORMAT, ERR_NONE);
          r.channel_count   = channels;
          r.sample_rate     = rate;
          r.byte_rate       = byte_rate;
          r.block_alignment = align;
          r.sample_bits     = bits;
          r.data_length     = v;
          parsed_results.push_back(r);
          if (v == 0) phase = P_DONE;
          else phase = P_DATA;
        end
        P_DATA: begin
          data_left--;
          r = blank(KIND_DATA, ERR_NONE);
          r.data_byte = b;
          if (data_left == 0) begin
            r.last_data = 1'b1;
            phase = P_DONE;
          end
          parsed_results.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) report($sformatf("%s expected %0h, actual %0h", name, want, got));
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (parsed_results.size() == 0) begin
        report($sformatf("unexpected word, kind %0h error %0h", got.result_kind,
                         got.error_code));
        return;
      end
      want = parsed_results.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("error_code", want.error_code, got.error_code);
      compare_field("channel_count", want.channel_count, got.channel_count);
      compare_field("sample_rate", want.sample_rate, got.sample_rate);
      compare_field("byte_rate", want.byte_rate, got.byte_rate);
      compare_field("block_alignment", want.block_alignment, got.block_alignment);
      compare_field("sample_bits", want.sample_bits, got.sample_bits);
      compare_field("data_length", want.data_length, got.data_length);
      compare_field("data_byte", want.data_byte, got.data_byte);
      compare_field("last_data", want.last_data, got.last_data);
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [ByteW-1:0]    s_tdata = '0;   // [7:0] file_byte
  logic                s_tuser = 1'b0; // [0] start_of_file
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;        // error_code, format fields, data_byte from bit 0 up
  logic [KindW-1:0]    m_tuser;        // [1:0] result_kind
  logic                m_tlast;        // last_data

  wav_parse_tracker parse_tracker;
  item_t            file_words[$];
  logic [7:0]       file_bytes[$];
  int unsigned      burst_left = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      rx_mode = 0, rx_left = 0, rx_tick = 0;

  wav_header_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // append a little-endian value to the file being built
  function automatic void put_le(logic [31:0] value, int unsigned nbytes);
    for (int i = 0; i < nbytes; i++) file_bytes.push_back(value[8*i +: 8]);
  endfunction

  // move the built file to the stimulus, start flag on its first byte
  function automatic void flush_file(logic first_sof);
    foreach (file_bytes[i]) file_words.push_back('{file_bytes[i], (i == 0) ? first_sof : 1'b0});
    file_bytes.delete();
  endfunction

  // field value with its extremes weighted in
  function automatic logic [31:0] pick_field(int unsigned nbits);
    logic [31:0] mask;
    mask = (nbits >= 32) ? 32'hFFFF_FFFF : ((32'd1 << nbits) - 1);
    case ($urandom_range(0, 5))
      0: return '0;
      1: return mask;
      default: return $urandom & mask;
    endcase
  endfunction

  // one random wave file, mostly well formed; returns its byte count
  function automatic int unsigned queue_file();
    logic [31:0] fmt_size, tag, chunk_size, data_size;
    logic [15:0] extra_size;
    int unsigned spot, cut, n_bytes;
    put_le(TAG_RIFF, 4);
    put_le(pick_field(32), 4);
    put_le(TAG_WAVE, 4);
    put_le(TAG_FMT, 4);
    case ($urandom_range(0, 5))
      0: fmt_size = BASE_FMT_SIZE;
      1: fmt_size = $urandom_range(0, 15);
      2: fmt_size = 32'hFFFF_FFFF;
      3: fmt_size = $urandom;
      default: fmt_size = BASE_FMT_SIZE + $urandom_range(1, 30);
    endcase
    put_le(fmt_size, 4);
    put_le(($urandom_range(0, 7) == 0) ? pick_field(16) : 32'(FMT_PCM), 2);
    put_le(pick_field(16), 2);
    put_le(pick_field(32), 4);
    put_le(pick_field(32), 4);
    put_le(pick_field(16), 2);
    put_le(pick_field(16), 2);
    // extra format bytes; a huge count swallows the rest of the file
    if (fmt_size > BASE_FMT_SIZE) begin
      extra_size = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 6));
      put_le(extra_size, 2);
      repeat ((extra_size == 16'hFFFF) ? $urandom_range(1, 8) : extra_size) put_le($urandom, 1);
    end
    // chunks ahead of data
    repeat ($urandom_range(0, 2)) begin
      tag = pick_field(32);
      if (tag == TAG_DATA) tag[0] = ~tag[0];
      put_le(tag, 4);
      case ($urandom_range(0, 5))
        0: chunk_size = '0;
        1: chunk_size = 32'hFFFF_FFFF;
        default: chunk_size = $urandom_range(1, 10);
      endcase
      put_le(chunk_size, 4);
      repeat ((chunk_size <= 10) ? chunk_size : $urandom_range(1, 6)) put_le($urandom, 1);
    end
    put_le(TAG_DATA, 4);
    case ($urandom_range(0, 7))
      0: data_size = '0;
      1: data_size = 32'hFFFF_FFFF;
      2: data_size = $urandom;
      default: data_size = $urandom_range(1, 24);
    endcase
    put_le(data_size, 4);
    repeat ((data_size <= 24) ? data_size : $urandom_range(1, 16)) put_le($urandom, 1);
    // broken tag in the header
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: spot = 0;
        1: spot = 8;
        default: spot = 12;
      endcase
      spot += $urandom_range(0, 3);
      file_bytes[spot] ^= 8'($urandom_range(1, 255));
    end
    // file cut short, the next start flag restarts the parse
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
    n_bytes = file_bytes.size();
    flush_file(1'b1);
    // trailing noise, normally dropped
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) put_le($urandom, 1);
      flush_file(1'b0);
    end
    return n_bytes;
  endfunction

  // send one word, with random gaps between bursts
  task automatic send_word(item_t w);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= w.file_byte;
    s_tuser  <= w.start_of_file;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // receiver stall pattern, changing mode whenever its mode counter runs out
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 4) == 0);
      default: m_tready <= ((rx_tick % 7) < 4);
    endcase
  end

  // sample both handshakes at the edge, watchdog on lack of progress
  always @(posedge clk) begin : watch
    result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) parse_tracker.note_byte(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        got = '0;
        got.result_kind     = m_tuser;
        got.error_code      = m_tdata[2:0];
        got.channel_count   = m_tdata[18:3];
        got.sample_rate     = m_tdata[50:19];
        got.byte_rate       = m_tdata[82:51];
        got.block_alignment = m_tdata[98:83];
        got.sample_bits     = m_tdata[114:99];
        got.data_length     = m_tdata[146:115];
        got.data_byte       = m_tdata[154:147];
        got.last_data       = m_tlast;
        parse_tracker.check_result(got);
      end
    end
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_wav_header_parser: errors");
      $finish;
    end
  end

  initial begin : main
    int unsigned file_total;
    parse_tracker = new();
    file_total = 0;

    // all-zero riff tag right after reset, without a start flag
    put_le(32'd0, 4);
    put_le(8'hFF, 1);
    flush_file(1'b0);
    // wave tag wrong in its last byte, then dropped bytes
    put_le(TAG_RIFF, 4);
    put_le(32'hFFFF_FFFF, 4);
    put_le(TAG_WAVE ^ 32'h8000_0000, 4);
    flush_file(1'b1);
    put_le(16'h00FF, 2);
    flush_file(1'b0);

    while (file_total < FILE_BYTE_GOAL) file_total += queue_file();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (file_words[i]) send_word(file_words[i]);
    s_tvalid <= 1'b0;

    // let the monitor note the last accepted word before draining
    @(posedge clk);
    while (parse_tracker.parsed_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (parse_tracker.mismatches == 0) $display("tb_wav_header_parser: clean");
    else $display("tb_wav_header_parser: errors");
    $finish;
  end

endmodule
